FILE: hdl/kv_request_deframer_top_assert.svh
// Assertion macros for the request deframer.
`ifndef KV_REQUEST_DEFRAMER_TOP_ASSERT_SVH
`define KV_REQUEST_DEFRAMER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define KVD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kvd assertion failed");
// Next-cycle implication, checked out of reset.
`define KVD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kvd assertion failed");
`else
`define KVD_ASSERT_SAME(label, ante, cons)
`define KVD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hdl/kvd_pkg.sv
// Types and constants shared by the request deframer modules.
`timescale 1ns / 1ps
package kvd_pkg;

  // byte roles
  localparam logic [2:0] ROLE_OUTER   = 3'd0;
  localparam logic [2:0] ROLE_COUNT   = 3'd1;
  localparam logic [2:0] ROLE_ARGLEN  = 3'd2;
  localparam logic [2:0] ROLE_ARGDATA = 3'd3;
  localparam logic [2:0] ROLE_DISCARD = 3'd4;

  // verdicts
  localparam logic [2:0] VERD_NONE      = 3'd0;
  localparam logic [2:0] VERD_GET       = 3'd1;
  localparam logic [2:0] VERD_SET       = 3'd2;
  localparam logic [2:0] VERD_DEL       = 3'd3;
  localparam logic [2:0] VERD_UNKNOWN   = 3'd4;
  localparam logic [2:0] VERD_MALFORMED = 3'd5;
  localparam logic [2:0] VERD_TOO_LONG  = 3'd6;

  // parser phases
  localparam logic [1:0] PH_OUTER  = 2'd0;
  localparam logic [1:0] PH_COUNT  = 2'd1;
  localparam logic [1:0] PH_ARGLEN = 2'd2;
  localparam logic [1:0] PH_DATA   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_MAX_MESSAGE_LEN = 2'd0;
  localparam logic [1:0] REG_MAX_ARG_COUNT   = 2'd1;

  localparam logic [12:0] MAX_MESSAGE_LEN_RST = 13'd4096;
  localparam logic [10:0] MAX_ARG_COUNT_RST   = 11'd1024;

  // candidate command bits
  localparam int CMD_GET = 0;
  localparam int CMD_SET = 1;
  localparam int CMD_DEL = 2;

  typedef struct packed {
    logic [7:0] data_out;
    logic [2:0] byte_role;
    logic [9:0] arg_index;
    logic       arg_last_byte;
    logic       message_end;
    logic [2:0] verdict;
  } kvd_result_t;

  // Character k of command c ("get", "set", "del").
  function automatic logic [7:0] cmd_char(input logic [1:0] c, input logic [1:0] k);
    logic [7:0] ch;
    ch = 8'h00;
    case ({c, k})
      4'b00_00: ch = "g";
      4'b00_01: ch = "e";
      4'b00_10: ch = "t";
      4'b01_00: ch = "s";
      4'b01_01: ch = "e";
      4'b01_10: ch = "t";
      4'b10_00: ch = "d";
      4'b10_01: ch = "e";
      4'b10_10: ch = "l";
      default:  ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

FILE: hdl/kvd_parser.sv
// Per-byte framing state and tagging logic of the request deframer.
`timescale 1ns / 1ps
module kvd_parser
  import kvd_pkg::*;
#(
  parameter int MESSAGE_CAPACITY = 4096,
  parameter int ARG_CAPACITY     = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_en,
  input  logic [7:0]  byte_in,
  input  logic [12:0] max_message_len,
  input  logic [10:0] max_arg_count,
  output kvd_result_t result
);

  localparam int BL_W = $clog2(MESSAGE_CAPACITY + 1);
  localparam int AC_W = $clog2(ARG_CAPACITY + 1);

  logic [1:0]      phase_r, phase_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [23:0]     acc_r, acc_nxt;
  logic [BL_W-1:0] len_r, len_nxt;
  logic [BL_W-1:0] pos_r, pos_nxt;
  logic [AC_W-1:0] args_r, args_nxt;
  logic [BL_W-1:0] abr_r, abr_nxt;
  logic [AC_W-1:0] cur_r, cur_nxt;
  logic [2:0]      cmd_r, cmd_nxt;
  logic            dead_r, dead_nxt;

  logic [31:0]     lim_msg, lim_args, val;
  logic            complete;
  logic [BL_W-1:0] pos_inc, rem, abr_dec;
  logic [1:0]      k;
  logic            go_fail, go_finish, go_argdone, go_need;
  logic [2:0]      fail_v;

  assign lim_msg  = (32'(max_message_len) < 32'(MESSAGE_CAPACITY)) ?
                    32'(max_message_len) : 32'(MESSAGE_CAPACITY);
  assign lim_args = (32'(max_arg_count) < 32'(ARG_CAPACITY)) ?
                    32'(max_arg_count) : 32'(ARG_CAPACITY);
  assign complete = (cnt_r == 2'd3);
  assign val      = {byte_in, acc_r};
  assign pos_inc  = pos_r + BL_W'(1);
  assign rem      = len_r - pos_inc;
  assign abr_dec  = (abr_r != '0) ? abr_r - BL_W'(1) : abr_r;
  assign k        = 2'd3 - abr_r[1:0];

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    args_nxt   = args_r;
    abr_nxt    = abr_r;
    cur_nxt    = cur_r;
    cmd_nxt    = cmd_r;
    dead_nxt   = dead_r;
    go_fail    = 1'b0;
    go_finish  = 1'b0;
    go_argdone = 1'b0;
    go_need    = 1'b0;
    fail_v     = VERD_MALFORMED;

    result.data_out      = byte_in;
    result.byte_role     = ROLE_DISCARD;
    result.arg_index     = '0;
    result.arg_last_byte = 1'b0;
    result.message_end   = 1'b0;
    result.verdict       = VERD_NONE;

    if (!dead_r) begin
      // shift the byte into the length field unless it closes the field
      if (phase_r != PH_DATA) begin
        cnt_nxt = cnt_r + 2'd1;
        case (cnt_r)
          2'd0:    acc_nxt = {acc_r[23:8], byte_in};
          2'd1:    acc_nxt = {acc_r[23:16], byte_in, acc_r[7:0]};
          2'd2:    acc_nxt = {byte_in, acc_r[15:0]};
          default: acc_nxt = '0;
        endcase
      end

      case (phase_r)
        PH_OUTER: begin
          result.byte_role = ROLE_OUTER;
          if (complete) begin
            if (val > lim_msg) begin
              go_fail = 1'b1;
              fail_v  = VERD_TOO_LONG;
            end else if (val < 32'd4) begin
              go_fail = 1'b1;
            end else begin
              len_nxt   = BL_W'(val);
              pos_nxt   = '0;
              phase_nxt = PH_COUNT;
            end
          end
        end
        PH_COUNT: begin
          result.byte_role = ROLE_COUNT;
          pos_nxt = pos_inc;
          if (complete) begin
            cur_nxt = '0;
            if (val > lim_args) begin
              go_fail = 1'b1;
            end else if (val == 32'd0) begin
              if (pos_inc == len_r) go_finish = 1'b1;
              else go_fail = 1'b1;
            end else begin
              args_nxt = AC_W'(val);
              go_need  = 1'b1;
            end
          end
        end
        PH_ARGLEN: begin
          result.byte_role = ROLE_ARGLEN;
          result.arg_index = 10'(cur_r);
          pos_nxt = pos_inc;
          if (complete) begin
            if (val > 32'(rem)) begin
              go_fail = 1'b1;
            end else begin
              if (cur_r == '0 && val != 32'd3) cmd_nxt = '0;
              if (val == 32'd0) begin
                go_argdone = 1'b1;
              end else begin
                abr_nxt   = BL_W'(val);
                phase_nxt = PH_DATA;
              end
            end
          end
        end
        default: begin
          result.byte_role = ROLE_ARGDATA;
          result.arg_index = 10'(cur_r);
          pos_nxt = pos_inc;
          // compare the command name while the first argument streams by
          if (cur_r == '0 && abr_r != '0 && abr_r <= BL_W'(3)) begin
            for (int c = 0; c < 3; c++) begin
              if (cmd_char(2'(c), k) != byte_in) cmd_nxt[c] = 1'b0;
            end
          end
          abr_nxt = abr_dec;
          if (abr_dec == '0) go_argdone = 1'b1;
        end
      endcase

      if (go_argdone) begin
        result.arg_last_byte = 1'b1;
        args_nxt = args_r - AC_W'(1);
        cur_nxt  = cur_r + AC_W'(1);
        if (args_nxt == '0) begin
          if (pos_inc == len_r) go_finish = 1'b1;
          else go_fail = 1'b1;
        end else begin
          go_need = 1'b1;
        end
      end

      if (go_need) begin
        if (rem < BL_W'(4)) go_fail = 1'b1;
        else phase_nxt = PH_ARGLEN;
      end

      if (go_finish) begin
        result.message_end = 1'b1;
        if (cur_nxt == AC_W'(2) && cmd_nxt[CMD_GET])      result.verdict = VERD_GET;
        else if (cur_nxt == AC_W'(3) && cmd_nxt[CMD_SET]) result.verdict = VERD_SET;
        else if (cur_nxt == AC_W'(2) && cmd_nxt[CMD_DEL]) result.verdict = VERD_DEL;
        else                                              result.verdict = VERD_UNKNOWN;
        // start the next message
        phase_nxt = PH_OUTER;
        cnt_nxt   = '0;
        acc_nxt   = '0;
        len_nxt   = '0;
        pos_nxt   = '0;
        args_nxt  = '0;
        abr_nxt   = '0;
        cur_nxt   = '0;
        cmd_nxt   = 3'b111;
      end

      if (go_fail) begin
        result.message_end = 1'b1;
        result.verdict     = fail_v;
        dead_nxt           = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OUTER;
      cnt_r   <= '0;
      acc_r   <= '0;
      len_r   <= '0;
      pos_r   <= '0;
      args_r  <= '0;
      abr_r   <= '0;
      cur_r   <= '0;
      cmd_r   <= 3'b111;
      dead_r  <= 1'b0;
    end else if (byte_en) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      args_r  <= args_nxt;
      abr_r   <= abr_nxt;
      cur_r   <= cur_nxt;
      cmd_r   <= cmd_nxt;
      dead_r  <= dead_nxt;
    end
  end

endmodule

FILE: hdl/kv_request_deframer_top.sv
// Key-value request deframer: stream ports, configuration and output buffering.
//
// Request bytes enter on the in_ stream, one byte per transfer. Each byte
// leaves on the out_ stream tagged with its role (tuser), its argument index,
// an end-of-argument flag and, on the byte that closes or fails a message,
// tlast and a verdict (get, set, del, unknown, malformed, too long).
// A malformed or too-long message is fatal: every later byte is tagged as
// discarded until reset.
// An accepted byte is registered into the output register, or into the skid
// buffer while the receiver stalls, before it is offered on out_. One byte is
// taken per cycle while in_tready is high; the framing counters update once per byte.
// The output register is backed by a one-entry skid buffer, so in_tready is
// a registered signal; when the receiver stalls, one more byte is absorbed
// and then in_tready drops until the skid entry drains.
// cfg_ writes limits (index 0: max message length, index 1: max argument count);
// the user must write only while no transfer is in flight; this is not enforced.
// Reset (rst_n low, synchronous) clears both buffers, the framing state and
// the dead flag, and restores limits of 4096 bytes and 1024 arguments.
`timescale 1ns / 1ps
module kv_request_deframer_top
  import kvd_pkg::*;
#(
  parameter int MESSAGE_CAPACITY = 4096,
  parameter int ARG_CAPACITY     = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] data_out, [17:8] arg_index,
                                  // [18] arg_last_byte, [21:19] verdict, [23:22] zero
  output logic [2:0]  out_tuser,  // [2:0] byte_role
  output logic        out_tlast,  // message_end
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [12:0] cfg_wdata
);

`include "kv_request_deframer_top_assert.svh"

  logic [12:0] max_message_len_r;
  logic [10:0] max_arg_count_r;
  logic        in_xfer;
  kvd_result_t res;
  kvd_result_t out_r, out_nxt, skid_r;
  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_message_len_r <= MAX_MESSAGE_LEN_RST;
      max_arg_count_r   <= MAX_ARG_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAX_MESSAGE_LEN: max_message_len_r <= cfg_wdata;
        REG_MAX_ARG_COUNT:   max_arg_count_r   <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !skid_valid_r;
  assign in_xfer   = in_tvalid && in_tready;

  kvd_parser #(
    .MESSAGE_CAPACITY(MESSAGE_CAPACITY),
    .ARG_CAPACITY    (ARG_CAPACITY)
  ) u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .byte_en        (in_xfer),
    .byte_in        (in_tdata),
    .max_message_len(max_message_len_r),
    .max_arg_count  (max_arg_count_r),
    .result         (res)
  );

  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_tready) begin
      // output slot frees up: refill from skid first, then from the parser
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res;
        out_valid_nxt = in_xfer;
      end
    end else if (in_xfer) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (in_xfer && out_valid_r && !out_tready) skid_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r.verdict, out_r.arg_last_byte, out_r.arg_index,
                       out_r.data_out};
  assign out_tuser  = out_r.byte_role;
  assign out_tlast  = out_r.message_end;

  `KVD_ASSERT_SAME(a_skid_implies_out, skid_valid_r, out_valid_r)
  `KVD_ASSERT_NEXT(a_accept_lands, in_xfer, out_valid_r)
  `KVD_ASSERT_SAME(a_verdict_on_end, out_valid_r && !out_r.message_end,
                   out_r.verdict == VERD_NONE)
  `KVD_ASSERT_SAME(a_last_in_arg, out_valid_r && out_r.arg_last_byte,
                   out_r.byte_role == ROLE_ARGLEN || out_r.byte_role == ROLE_ARGDATA)

endmodule
